FILE: rtl/core/pcmfc_pkg.sv
// Shared widths, format codes and register indexes of the PCM sample format converter.
package pcmfc_pkg;

    localparam int SAMPLE_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    typedef logic [2:0] t_fmt;

    localparam t_fmt FMT_S16 = 3'd0;
    localparam t_fmt FMT_U16 = 3'd1;
    localparam t_fmt FMT_S32 = 3'd2;
    localparam t_fmt FMT_U32 = 3'd3;
    localparam t_fmt FMT_FLT = 3'd4;
    localparam t_fmt FMT_DBL = 3'd5;
    localparam t_fmt FMT_S8  = 3'd6;
    localparam t_fmt FMT_U8  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FMT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BYTES = 2'd2;

endpackage

FILE: rtl/core/pcmfc_in_if.sv
// Input word channel of the PCM sample format converter.
interface pcmfc_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcmfc_pkg::SAMPLE_W-1:0] sample_in;
    logic                           last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

FILE: rtl/core/pcmfc_out_if.sv
// Result word channel of the PCM sample format converter.
interface pcmfc_out_if;
    logic                           valid;
    logic                           ready;
    logic [pcmfc_pkg::SAMPLE_W-1:0] sample_out;
    logic                           last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

FILE: rtl/core/pcm_sample_format_converter.sv
// Top level of the PCM sample format converter.
// One word is accepted per clock while the output is not stalled, and its result is
// presented once it has passed both registers: the first register holds the incoming
// word, the second holds the converted word, and the
// conversion (a 24 by 15 bit constant multiply with rounding for float to s16, or an
// exact division by 32767 through a reciprocal sum and remainder correction for s16 to
// float) sits between them. Both stages move whenever the result stage is empty or
// being taken, so the sustained rate is one word per clock. Configuration is written
// through a plain write port and must only change while the block is idle.
module pcm_sample_format_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcmfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcmfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pcmfc_in_if.sink                         i_in,
    pcmfc_out_if.source                      o_out
);

    function automatic logic [15:0] flt_to_s16(input logic [31:0] bits);
        logic        s;
        logic [7:0]  e;
        logic [23:0] m;
        logic [38:0] p;
        logic [23:0] keep;
        logic        g;
        logic        st;
        logic [4:0]  sh;
        logic [24:0] r;
        logic [15:0] mag;
        logic [15:0] res;
        s = bits[31];
        e = bits[30:23];
        m = {1'b1, bits[22:0]};
        p = {m, 15'd0} - {15'd0, m};
        if (p[38]) begin
            keep = p[38:15];
            g    = p[14];
            st   = |p[13:0];
            sh   = 5'(8'd135 - e);
        end else begin
            keep = p[37:14];
            g    = p[13];
            st   = |p[12:0];
            sh   = 5'(8'd136 - e);
        end
        r   = {1'b0, keep} + {24'd0, g & (st | keep[0])};
        mag = 16'(r >> sh);
        if (e == 8'hFF && bits[22:0] != 23'd0) begin
            res = 16'h7FFF;
        end else if (e >= 8'd127) begin
            res = s ? 16'h8001 : 16'h7FFF;
        end else if (e < 8'd111) begin
            res = 16'h0000;
        end else begin
            res = s ? 16'(-mag) : mag;
        end
        return res;
    endfunction

    function automatic logic [31:0] s16_to_flt(input logic [15:0] u);
        logic        sg;
        logic [15:0] a;
        logic [3:0]  lz;
        logic [15:0] n;
        logic [40:0] x;
        logic [26:0] t;
        logic [42:0] rw;
        logic [16:0] r;
        logic [26:0] q;
        logic [16:0] rem;
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [7:0]  ex;
        logic [24:0] mr;
        logic [31:0] res;
        sg = u[15];
        a  = sg ? 16'(-u) : u;
        lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (a[i]) lz = 4'(15 - i);
        end
        n  = a << lz;
        x  = {n, 25'd0};
        // Reciprocal of 2^15-1 as a sum of shifts, then fix the quotient from the remainder.
        t  = 27'(x[40:15]) + 27'(x[40:30]);
        rw = {2'b00, x} + 43'(t) - ({16'd0, t} << 15);
        r  = rw[16:0];
        if (r >= 17'd65534) begin
            q   = t + 27'd2;
            rem = r - 17'd65534;
        end else if (r >= 17'd32767) begin
            q   = t + 27'd1;
            rem = r - 17'd32767;
        end else begin
            q   = t;
            rem = r;
        end
        if (q[26]) begin
            mant = q[26:3];
            g    = q[2];
            st   = (|q[1:0]) | (rem != 17'd0);
            ex   = 8'd128 - {4'd0, lz};
        end else begin
            mant = q[25:2];
            g    = q[1];
            st   = q[0] | (rem != 17'd0);
            ex   = 8'd127 - {4'd0, lz};
        end
        mr = {1'b0, mant} + {24'd0, g & (st | mant[0])};
        if (mr[24]) begin
            res = {sg, ex + 8'd1, 23'd0};
        end else begin
            res = {sg, ex, mr[22:0]};
        end
        if (a == 16'd0) res = 32'd0;
        return res;
    endfunction

    function automatic logic [3:0] src_bytes(input pcmfc_pkg::t_fmt f);
        logic [3:0] b;
        case (f)
            pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_U16: b = 4'd2;
            pcmfc_pkg::FMT_S32, pcmfc_pkg::FMT_U32, pcmfc_pkg::FMT_FLT: b = 4'd4;
            pcmfc_pkg::FMT_DBL: b = 4'd8;
            default: b = 4'd1;
        endcase
        return b;
    endfunction

    function automatic logic [pcmfc_pkg::SAMPLE_W-1:0] byte_mask(input logic [3:0] nb);
        logic [pcmfc_pkg::SAMPLE_W-1:0] mk;
        for (int i = 0; i < pcmfc_pkg::SAMPLE_W / 8; i++) begin
            mk[i*8 +: 8] = (4'(i) < nb) ? 8'hFF : 8'h00;
        end
        return mk;
    endfunction

    pcmfc_pkg::t_fmt r_src_fmt;
    pcmfc_pkg::t_fmt r_dst_fmt;
    logic [3:0]      r_dst_bytes;

    logic                           r_in_valid;
    logic [pcmfc_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                           r_in_last;
    logic                           r_out_valid;
    logic [pcmfc_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                           r_out_last;

    logic                           advance;
    logic                           in_ready;
    logic [3:0]                     db;
    logic [3:0]                     sb;
    logic [pcmfc_pkg::SAMPLE_W-1:0] raw;
    logic [pcmfc_pkg::SAMPLE_W-1:0] n_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt   <= pcmfc_pkg::FMT_FLT;
            r_dst_fmt   <= pcmfc_pkg::FMT_S16;
            r_dst_bytes <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcmfc_pkg::CFG_SRC_FMT:   r_src_fmt   <= i_cfg_data[2:0];
                pcmfc_pkg::CFG_DST_FMT:   r_dst_fmt   <= i_cfg_data[2:0];
                pcmfc_pkg::CFG_DST_BYTES: r_dst_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || advance;

    always_comb begin
        db = (r_dst_bytes > 4'd8) ? 4'd8 : r_dst_bytes;
        sb = src_bytes(r_src_fmt);
        if (r_src_fmt == pcmfc_pkg::FMT_FLT && r_dst_fmt == pcmfc_pkg::FMT_S16) begin
            raw = {48'd0, flt_to_s16(r_in_sample[31:0])};
        end else if (r_src_fmt == pcmfc_pkg::FMT_S16 && r_dst_fmt == pcmfc_pkg::FMT_FLT) begin
            raw = {32'd0, s16_to_flt(r_in_sample[15:0])};
        end else if (r_src_fmt == pcmfc_pkg::FMT_FLT && r_dst_fmt == pcmfc_pkg::FMT_FLT) begin
            raw = {32'd0, r_in_sample[31:0]};
        end else if (r_src_fmt == pcmfc_pkg::FMT_S16 && r_dst_fmt == pcmfc_pkg::FMT_S16) begin
            raw = {48'd0, r_in_sample[15:0]};
        end else begin
            raw = r_in_sample & byte_mask((sb < db) ? sb : db);
        end
        n_out_sample = raw & byte_mask(db);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) r_in_valid <= i_in.valid;
            if (advance)  r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_sample <= i_in.sample_in;
            r_in_last   <= i_in.last_in;
        end
        if (advance && r_in_valid) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= r_in_last;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.last_out   = r_out_last;

endmodule

FILE: rtl/core/pcmfc_checker.sv
// Port-level checks of the PCM sample format converter, bound to its top level.
module pcmfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [pcmfc_pkg::SAMPLE_W-1:0] i_out_sample,
    input logic                           i_out_last
);

    // A stalled result keeps its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample)
            && $stable(i_out_last))
        else $error("result word changed while stalled");

    // No result may appear straight after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With the result stage empty the pipeline can always take a word.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty result stage");

    // When the result is being taken the input side never stalls.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while results drain");

endmodule

bind pcm_sample_format_converter pcmfc_checker u_pcmfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_last   (o_out.last_out)
);

FILE: tb/sv/pcm_sample_format_converter_tb.sv
// Self-checking testbench for the PCM sample format converter.
`timescale 1ns / 100ps

module pcm_sample_format_converter_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [pcmfc_pkg::SAMPLE_W-1:0] sample;
        logic                           last;
    } t_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pcmfc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [pcmfc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pcmfc_in_if  in_ch ();
    pcmfc_out_if out_ch ();

    pcm_sample_format_converter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow copy of the converter's registers.
    pcmfc_pkg::t_fmt src_fmt;
    pcmfc_pkg::t_fmt dst_fmt;
    logic [3:0]      dst_bytes;

    t_word pending_words[$];
    int    error_count;
    int    words_sent;
    int    words_checked;
    int    cycle_count;
    int    burst_left;
    bit    bursty;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] byte_window(input int n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Works out the converted word for the current register settings.
    function automatic t_word convert_word(input logic [63:0] smp, input logic lst);
        t_word       res;
        int          db;
        int          sb;
        int          ex;
        int          s;
        int          k;
        longint      prod;
        longint      q;
        longint      rem;
        longint      half;
        longint      mag;
        logic [31:0] fb;
        logic [15:0] h;
        logic [63:0] value;
        db = (dst_bytes > 4'd8) ? 8 : int'(dst_bytes);
        case (src_fmt)
            pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_U16: sb = 2;
            pcmfc_pkg::FMT_S32, pcmfc_pkg::FMT_U32, pcmfc_pkg::FMT_FLT: sb = 4;
            pcmfc_pkg::FMT_DBL: sb = 8;
            default: sb = 1;
        endcase
        if (src_fmt == pcmfc_pkg::FMT_FLT && dst_fmt == pcmfc_pkg::FMT_S16) begin
            fb = smp[31:0];
            ex = int'(fb[30:23]);
            if (ex == 255 && fb[22:0] != 0) begin
                mag = 32767;
            end else if (ex >= 127) begin
                mag = fb[31] ? -32767 : 32767;
            end else if (ex == 0) begin
                mag = 0;
            end else begin
                // Exact product, then rounded to a 24-bit significand, then truncated.
                prod = longint'({1'b1, fb[22:0]}) * 32767;
                s = 0;
                while ((prod >> s) >= (64'd1 << 24)) s++;
                q = prod >> s;
                if (s > 0) begin
                    rem = prod & ((64'd1 << s) - 1);
                    half = 64'd1 << (s - 1);
                    if (rem > half || (rem == half && q[0])) q++;
                end
                s = 150 - ex - s;
                mag = (s >= 60) ? 0 : (q >> s);
                if (fb[31]) mag = -mag;
            end
            value = {48'd0, mag[15:0]};
        end else if (src_fmt == pcmfc_pkg::FMT_S16 && dst_fmt == pcmfc_pkg::FMT_FLT) begin
            h = smp[15:0];
            if (h == 16'd0) begin
                value = 64'd0;
            end else begin
                mag = h[15] ? (65536 - longint'(h)) : longint'(h);
                k = 0;
                q = mag / 32767;
                while (q < (64'd1 << 23)) begin
                    k++;
                    q = (mag << k) / 32767;
                end
                rem = (mag << k) % 32767;
                if (2 * rem > 32767) q++;
                if (q == (64'd1 << 24)) begin
                    q = q >> 1;
                    k--;
                end
                ex = 150 - k;
                value = {32'd0, h[15], ex[7:0], q[22:0]};
            end
        end else if (src_fmt == pcmfc_pkg::FMT_FLT && dst_fmt == pcmfc_pkg::FMT_FLT) begin
            value = smp & 64'hFFFF_FFFF;
        end else if (src_fmt == pcmfc_pkg::FMT_S16 && dst_fmt == pcmfc_pkg::FMT_S16) begin
            value = smp & 64'hFFFF;
        end else begin
            value = smp & byte_window((sb < db) ? sb : db);
        end
        res.sample = value & byte_window(db);
        res.last = lst;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] mismatch in %s: expected %h, got %h", $time, what, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_word want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d words outstanding", $time,
                     pending_words.size());
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 64'd0, out_ch.sample_out);
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (out_ch.sample_out !== want.sample)
                    report_mismatch("sample_out", want.sample, out_ch.sample_out);
                if (out_ch.last_out !== want.last)
                    report_mismatch("last_out", 64'(want.last), 64'(out_ch.last_out));
            end
        end
    end

    // The receiver switches at random between always ready, mostly ready and coin-toss stall habits.
    int stall_mode;
    int stall_tick;
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic send_word(input logic [63:0] smp, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = bursty ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= smp;
        in_ch.last_in <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_words.push_back(convert_word(smp, lst));
        burst_left--;
        words_sent++;
    endtask

    // Stops the sender and waits until every converted word has been taken.
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [pcmfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [3:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pcmfc_pkg::CFG_SRC_FMT: src_fmt = data[2:0];
            pcmfc_pkg::CFG_DST_FMT: dst_fmt = data[2:0];
            default: dst_bytes = data;
        endcase
    endtask

    task automatic set_formats(input pcmfc_pkg::t_fmt sf, input pcmfc_pkg::t_fmt df,
                               input logic [3:0] db);
        drain();
        write_reg(pcmfc_pkg::CFG_SRC_FMT, {1'b0, sf});
        write_reg(pcmfc_pkg::CFG_DST_FMT, {1'b0, df});
        write_reg(pcmfc_pkg::CFG_DST_BYTES, db);
    endtask

    // Reset settings: float32 to s16 with clamping, NaN and rounding corners.
    task automatic test_float_to_s16;
        send_word(64'h0000_0000_0000_0000, 1'b0);
        send_word(64'h0000_0000_3F80_0000, 1'b0);
        send_word(64'h0000_0000_BF80_0000, 1'b1);
        send_word(64'h0000_0000_7F80_0000, 1'b0);
        send_word(64'h0000_0000_FF80_0000, 1'b0);
        send_word(64'h0000_0000_7FC0_0000, 1'b1);
        send_word(64'h0000_0000_3F00_0000, 1'b0);
        send_word(64'h0000_0000_3F7F_FFFF, 1'b0);
        send_word(64'h0000_0000_BF7F_FFFF, 1'b1);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'hDEAD_BEEF_3E80_0000, 1'b1);
        send_word(64'hFFFF_FFFF_3800_0100, 1'b0);
    endtask

    task automatic test_s16_to_float;
        set_formats(pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_FLT, 4'd4);
        send_word(64'h0000_0000_0000_8000, 1'b0);
        send_word(64'h0000_0000_0000_7FFF, 1'b1);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'h0000_0000_0000_FFFF, 1'b0);
        send_word(64'h0000_0000_0000_0000, 1'b1);
        send_word(64'hFFFF_1234_0000_4000, 1'b0);
    endtask

    task automatic test_passthrough;
        set_formats(pcmfc_pkg::FMT_FLT, pcmfc_pkg::FMT_FLT, 4'd8);
        send_word(64'hA5A5_5A5A_C3C3_3C3C, 1'b1);
        set_formats(pcmfc_pkg::FMT_FLT, pcmfc_pkg::FMT_FLT, 4'd2);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        set_formats(pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_S16, 4'd8);
        send_word(64'h8765_4321_FEDC_BA98, 1'b1);
    endtask

    // Byte copy, including an empty slot and a slot wider than eight bytes.
    task automatic test_byte_copy;
        set_formats(pcmfc_pkg::FMT_DBL, pcmfc_pkg::FMT_U32, 4'd15);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        set_formats(pcmfc_pkg::FMT_U8, pcmfc_pkg::FMT_S32, 4'd0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        set_formats(pcmfc_pkg::FMT_S8, pcmfc_pkg::FMT_S8, 4'd8);
        send_word(64'h0123_4567_89AB_CDEF, 1'b1);
    endtask

    task automatic test_random;
        pcmfc_pkg::t_fmt sf;
        pcmfc_pkg::t_fmt df;
        logic [3:0]      db;
        logic [63:0]     smp;
        logic [31:0]     fb;
        int              pick;
        for (int phase = 0; phase < 13; phase++) begin
            pick = $urandom_range(0, 3);
            if (phase % 3 == 0 || pick == 0) begin
                sf = pcmfc_pkg::FMT_FLT;
                df = pcmfc_pkg::FMT_S16;
            end else if (phase % 3 == 1 || pick == 1) begin
                sf = pcmfc_pkg::FMT_S16;
                df = pcmfc_pkg::FMT_FLT;
            end else begin
                sf = pcmfc_pkg::t_fmt'($urandom_range(0, 7));
                df = pcmfc_pkg::t_fmt'($urandom_range(0, 7));
            end
            case (phase)
                0: db = 4'd0;
                1: db = 4'd15;
                2: db = 4'd8;
                3: db = 4'd1;
                default: db = 4'($urandom_range(0, 15));
            endcase
            set_formats(sf, df, db);
            bursty = (phase != 4);
            for (int n = 0; n < 110; n++) begin
                smp = {$urandom, $urandom};
                case ($urandom_range(0, 4))
                    0: ;
                    1, 2: begin
                        // A float in or just beyond the clamping range.
                        fb = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 128)),
                              23'($urandom)};
                        smp[31:0] = fb;
                    end
                    3: smp[31:0] = $urandom_range(0, 3) == 0 ? 32'h7FC0_0001 :
                                   {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
                    default: smp[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                endcase
                send_word(smp, 1'($urandom_range(0, 1)));
                if (phase == 6 && n == 55) drain();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        src_fmt = pcmfc_pkg::FMT_FLT;
        dst_fmt = pcmfc_pkg::FMT_S16;
        dst_bytes = 4'd2;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        cycle_count = 0;
        stall_mode = 0;
        stall_tick = 0;
        burst_left = 0;
        bursty = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_float_to_s16();
        test_s16_to_float();
        test_passthrough();
        test_byte_copy();
        test_random();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Converted %0d words and checked %0d across float, s16 and byte copy modes,",
                 words_sent, words_checked);
        $display("with slot widths from zero to fifteen bytes; %0d mismatches.", error_count);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
